// ===== sv/sliding_window_max_macros.svh =====
// Assertion macros for the sliding window maximum block.
// Used by the top level; they expect clk and rst_n in scope.
`ifndef SLIDING_WINDOW_MAX_MACROS_SVH
`define SLIDING_WINDOW_MAX_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
// No dependencies; imported by swm_cell and sliding_window_max.
package swm_pkg;

    // Default sizes
    localparam int WINDOW_MAX_DEF = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Width of the window_size register
    localparam int CFG_W = 7;

    // Per-item sequencer states
    typedef enum logic
    {
        ST_IDLE,
        ST_WORK
    } swm_state_t;

    // Commands broadcast from the sequencer to every cell
    typedef struct packed
    {
        logic clear;    // empty the queue (start of sequence)
        logic age_inc;  // advance every candidate's age
        logic shift;    // drop the front candidate, move all toward the front
        logic append;   // drop dominated back entries and append the sample
    } swm_ctrl_t;

endpackage

// ===== sv/swm_cell.sv =====
// One candidate cell of the monotonic queue: value, age and valid flag.
// Depends on swm_pkg for the command struct.
module swm_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int AGE_W      = 7,
    parameter int WINDOW_MAX = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  swm_pkg::swm_ctrl_t           ctrl,
    input  logic signed [DATA_WIDTH-1:0] sample,     // newcomer
    input  logic                         prev_keep,  // cell toward the front survives
    input  logic                         nb_valid,   // cell toward the back
    input  logic signed [DATA_WIDTH-1:0] nb_value,
    input  logic        [AGE_W-1:0]      nb_age,
    output logic                         valid,
    output logic signed [DATA_WIDTH-1:0] value,
    output logic        [AGE_W-1:0]      age,
    output logic                         keep
);
    import swm_pkg::*;

    logic                         valid_reg;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic        [AGE_W-1:0]      age_reg;
    logic                         take_new;

    // Survive the append only if strictly above the newcomer
    assign keep     = valid_reg && (value_reg > sample);
    // Newcomer lands just behind the last survivor
    assign take_new = prev_keep && !keep;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= nb_valid;
        end
        else if (ctrl.append)
        begin
            valid_reg <= keep || take_new;
        end
    end

    // Value and age payload
    always_ff @(posedge clk)
    begin
        if (ctrl.age_inc)
        begin
            if (age_reg != AGE_W'(WINDOW_MAX))
            begin
                age_reg <= age_reg + AGE_W'(1);
            end
        end
        else if (ctrl.shift)
        begin
            value_reg <= nb_value;
            age_reg   <= nb_age;
        end
        else if (ctrl.append && take_new)
        begin
            value_reg <= sample;
            age_reg   <= '0;
        end
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

// ===== sv/sliding_window_max.sv =====
// Sliding window maximum: a slave stream of signed samples in, a master
// stream of window maxima out, one cfg write port for the window length.
//
// s_tdata carries the sample, s_tuser the start_of_sequence flag; a set flag
// empties the candidate queue and restarts the fill count before the sample.
// m_tdata carries window_max; one item leaves per sample once window_size
// samples of the current sequence have been seen, none before.
// In the common case each sample is first captured while the candidates age,
// then appended while the output register is loaded. Every candidate that
// has left the window costs an extra shift of the cell row toward the front
// before the append (at most one per sample unless window_size shrinks).
// m_tvalid rises once the ST_WORK append after acceptance loads the output
// register, when no expired candidate has to be dropped and that register is free.
// A finished result waits in the output register while the next sample is
// taken and aged; the append stalls only if the register is still full.
// Reset empties the queue, clears the fill count and sets window_size to 1.
// window_size 0 acts as 1; values above WINDOW_MAX act as WINDOW_MAX.
// Write cfg only while no item is in flight.
`include "sliding_window_max_macros.svh"

module sliding_window_max #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,   // [DATA_WIDTH-1:0] sample
    input  logic                                s_tuser,   // [0] start_of_sequence
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_tdata,   // [DATA_WIDTH-1:0] window_max
    input  logic                                cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]           cfg_wr_data // window_size
);
    import swm_pkg::*;

    localparam int AGE_W  = $clog2(WINDOW_MAX + 1);
    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    swm_state_t                   state_reg, state_next;
    logic [CFG_W-1:0]             ws_reg;
    logic [AGE_W-1:0]             fill_reg, fill_next;
    logic signed [DATA_WIDTH-1:0] sample_reg;
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] out_data_reg, out_data_next;

    swm_ctrl_t                    ctrl;
    logic [AGE_W-1:0]             win_len;
    logic [AGE_W-1:0]             fill_clamp;
    logic                         accept;
    logic                         drop_front;
    logic                         emit;
    logic                         stall;
    logic                         append_go;

    logic [WINDOW_MAX-1:0]        c_valid;
    logic [WINDOW_MAX-1:0]        c_keep;
    logic signed [DATA_WIDTH-1:0] c_value [WINDOW_MAX];
    logic [AGE_W-1:0]             c_age   [WINDOW_MAX];

    // Effective window length
    always_comb
    begin
        if (ws_reg == '0)
        begin
            win_len = AGE_W'(1);
        end
        else if (int'(ws_reg) > WINDOW_MAX)
        begin
            win_len = AGE_W'(WINDOW_MAX);
        end
        else
        begin
            win_len = AGE_W'(ws_reg);
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign drop_front = c_valid[0] && (c_age[0] >= win_len);
    assign fill_clamp = (fill_reg > win_len) ? win_len : fill_reg;
    assign emit       = ((fill_clamp < win_len) ? fill_clamp + AGE_W'(1) : fill_clamp)
                        >= win_len;
    assign stall      = emit && out_valid_reg && !m_tready;
    assign append_go  = (state_reg == ST_WORK) && !drop_front && !stall;

    // Sequencer: next state, cell commands, fill count and output register
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ctrl           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.clear   = s_tuser;
                    ctrl.age_inc = !s_tuser;
                    if (s_tuser)
                    begin
                        fill_next = '0;
                    end
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (drop_front)
                begin
                    ctrl.shift = 1'b1;
                end
                else if (!stall)
                begin
                    ctrl.append = 1'b1;
                    fill_next   = (fill_clamp < win_len) ? fill_clamp + AGE_W'(1)
                                                         : fill_clamp;
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = c_keep[0] ? c_value[0] : sample_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ws_reg        <= CFG_W'(1);
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                ws_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_tdata[DATA_WIDTH-1:0];
        end
        out_data_reg <= out_data_next;
    end

    // Row of candidate cells, front at index 0
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic                         prev_keep;
        logic                         nb_valid;
        logic signed [DATA_WIDTH-1:0] nb_value;
        logic [AGE_W-1:0]             nb_age;

        if (i == 0)
        begin : g_front
            assign prev_keep = 1'b1;
        end
        else
        begin : g_inner
            assign prev_keep = c_keep[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_back
            assign nb_valid = 1'b0;
            assign nb_value = '0;
            assign nb_age   = '0;
        end
        else
        begin : g_link
            assign nb_valid = c_valid[i+1];
            assign nb_value = c_value[i+1];
            assign nb_age   = c_age[i+1];
        end

        swm_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .AGE_W      (AGE_W),
            .WINDOW_MAX (WINDOW_MAX)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .sample    (sample_reg),
            .prev_keep (prev_keep),
            .nb_valid  (nb_valid),
            .nb_value  (nb_value),
            .nb_age    (nb_age),
            .valid     (c_valid[i]),
            .value     (c_value[i]),
            .age       (c_age[i]),
            .keep      (c_keep[i])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'($unsigned(out_data_reg));

    // Checks
    `SWM_ASSERT_NEXT(a_accept_work, accept, state_reg == ST_WORK,
        "accepted item did not start work")
    `SWM_ASSERT_NEXT(a_append_front, append_go, c_valid[0],
        "queue front empty after append")
    `SWM_ASSERT_NOW(a_valid_prefix, 1'b1, ((c_valid + WINDOW_MAX'(1)) & c_valid) == '0,
        "candidate cells not packed toward the front")

endmodule

// ===== verif/sliding_window_max_tb.sv =====
// Self-checking testbench for sliding_window_max: random and directed samples,
// window maxima predicted in place with a monotonic candidate queue.
// Depends on swm_pkg and the sliding_window_max RTL only.
module sliding_window_max_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_MAX    = swm_pkg::WINDOW_MAX_DEF;
    localparam int DW         = swm_pkg::DATA_WIDTH_DEF;
    localparam int CW         = swm_pkg::CFG_W;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_WAIT = 16;
    localparam int LONG_HOLD  = 400;

    typedef struct packed
    {
        logic                 sos;
        logic signed [DW-1:0] smp;
    } sample_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CW-1:0] cfg_wr_data = '0;

    // Stimulus and expectation stores
    sample_item_t pend_q[$];
    logic signed [DW-1:0] max_q[$];
    int errors = 0;
    int cycles = 0;

    // Idling controls, set per phase by the stimulus process
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    bit rx_long_hold = 1'b0;

    // Predictor state: candidate queue, fill count, window register
    logic signed [DW-1:0] cand_val[WIN_MAX];
    int unsigned cand_age[WIN_MAX];
    int cand_n = 0;
    int fill_n = 0;
    logic [CW-1:0] win_reg = CW'(1);
    logic signed [DW-1:0] last_sample = '0;

    int tx_gap = 0;
    int rx_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    sliding_window_max dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),     // [31:0] sample
        .s_tuser    (s_tuser),     // [0] start_of_sequence
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),     // [31:0] window_max
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)  // window_size
    );

    always #5 clk = ~clk;

    // Clamp the raw register value to the length the block actually uses
    function automatic int eff_window(input logic [CW-1:0] w);
        if (w == 0)
            return 1;
        if (w > WIN_MAX)
            return WIN_MAX;
        return int'(w);
    endfunction

    function automatic void pop_oldest_candidate();
        int i;
        for (i = 1; i < cand_n; i++)
        begin
            cand_val[i-1] = cand_val[i];
            cand_age[i-1] = cand_age[i];
        end
        cand_n--;
    endfunction

    // Advance the candidate queue by one sample; queue the maximum once full
    function automatic void predict_window_max(input logic signed [DW-1:0] smp,
                                               input logic sos);
        int k;
        int i;
        k = eff_window(win_reg);
        if (sos)
        begin
            cand_n = 0;
            fill_n = 0;
        end
        for (i = 0; i < cand_n; i++)
            if (cand_age[i] < WIN_MAX)
                cand_age[i]++;
        while (cand_n > 0 && cand_age[0] >= k)
            pop_oldest_candidate();
        while (cand_n > 0 && cand_val[cand_n-1] <= smp)
            cand_n--;
        if (cand_n >= WIN_MAX)
            pop_oldest_candidate();
        cand_val[cand_n] = smp;
        cand_age[cand_n] = 0;
        cand_n++;
        if (fill_n > k)
            fill_n = k;
        if (fill_n < k)
            fill_n++;
        if (fill_n >= k)
            max_q.insert(max_q.size(), cand_val[0]);
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap(input bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Mix full-range values, near-zero values with many ties, extremes and steps
    function automatic logic signed [DW-1:0] next_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            last_sample = $urandom;
        else if (r < 7)
            last_sample = $signed($urandom_range(0, 8)) - 4;
        else if (r < 8)
            last_sample = $urandom_range(0, 1) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            last_sample = last_sample + $signed($urandom_range(0, 6)) - 3;
        return last_sample;
    endfunction

    // Driver: predict on acceptance, then offer the next pending item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_window_max($signed(s_tdata[DW-1:0]), s_tuser);
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pend_q.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pend_q[0].smp;
                    s_tuser  <= pend_q[0].sos;
                    pend_q.delete(0);
                    tx_gap   <= pick_gap(tx_gaps_on);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted item, then decide the next ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_gap    <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (max_q.size() == 0)
                begin
                    $error("window_max: unexpected item %0d", $signed(m_tdata[DW-1:0]));
                    errors++;
                end
                else
                begin
                    if (m_tdata[DW-1:0] !== max_q[0])
                    begin
                        $error("window_max: expected %0d, actual %0d",
                               max_q[0], $signed(m_tdata[DW-1:0]));
                        errors++;
                    end
                    max_q.delete(0);
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
                if (hold_left == 1)
                    hold_done <= 1'b1;
            end
            else if (rx_long_hold && !hold_done)
            begin
                hold_left <= LONG_HOLD;
                m_tready  <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_gap   <= pick_gap(rx_gaps_on);
            end
        end
    end

    // Guard against a hung block
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Sample at the falling edge, after every update of the rising edge settled
    task automatic wait_all_done();
        @(negedge clk);
        while (pend_q.size() > 0 || s_tvalid || !s_tready || max_q.size() > 0)
            @(negedge clk);
    endtask

    // Let in-flight work finish, then write the window length
    task automatic set_window(input int w);
        wait_all_done();
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CW'(w);
        win_reg = CW'(w);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_item(input logic sos, input logic signed [DW-1:0] v);
        sample_item_t it;
        it.sos = sos;
        it.smp = v;
        pend_q.insert(pend_q.size(), it);
    endtask

    // Queue n samples as sequences, mostly long enough to fill the window
    task automatic queue_sequences(input int n, input bit carry_on);
        int k;
        int left;
        int i;
        logic sos;
        k = eff_window(win_reg);
        left = carry_on ? $urandom_range(1, k + 8) : 0;
        for (i = 0; i < n; i++)
        begin
            sos = 1'b0;
            if (left == 0)
            begin
                sos = 1'b1;
                left = ($urandom_range(0, 4) != 0) ? $urandom_range(k, 2 * k + 8)
                                                   : $urandom_range(1, k);
            end
            else if ($urandom_range(0, 59) == 0)
                sos = 1'b1;
            left--;
            queue_item(sos, next_sample());
        end
    endtask

    initial
    begin
        int win_plan[12];
        int p;

        win_plan = '{3, 0, 64, 5, 127, 2, 64, 1, 17, 40, 7, 65};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Window of 1 from reset: extremes pass straight through
        queue_item(1'b1, {1'b1, {(DW-1){1'b0}}});
        queue_item(1'b0, {1'b0, {(DW-1){1'b1}}});
        queue_item(1'b0, 0);
        queue_item(1'b0, -1);

        // Window of 3: ties, aging out of the front, extremes, restart mid-run
        set_window(3);
        queue_item(1'b1, 5);
        queue_item(1'b0, 5);
        queue_item(1'b0, 5);
        queue_item(1'b0, 4);
        queue_item(1'b0, 3);
        queue_item(1'b0, 2);
        queue_item(1'b0, {1'b1, {(DW-1){1'b0}}});
        queue_item(1'b0, {1'b0, {(DW-1){1'b1}}});
        queue_item(1'b1, 1);
        queue_item(1'b0, -1);
        queue_item(1'b0, 0);
        queue_item(1'b0, 7);
        queue_item(1'b0, 6);
        queue_item(1'b0, 6);

        // Receiver holds off while the sender keeps offering: block backs up
        set_window(1);
        tx_gaps_on = 1'b0;
        rx_long_hold = 1'b1;
        queue_sequences(200, 1'b0);
        wait_all_done();
        rx_long_hold = 1'b0;

        // Random phases; some keep the sequence running across the change
        for (p = 0; p < 12; p++)
        begin
            set_window(win_plan[p]);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            queue_sequences(45, (p % 3) != 0);
            if (p == 4)
                wait_all_done();
            queue_sequences(50, 1'b1);
        end

        wait_all_done();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/swm_pkg.sv
sv/swm_cell.sv
sv/sliding_window_max.sv
verif/sliding_window_max_tb.sv
